@@ rtl/rthsv_pkg.sv @@
`default_nettype none
package rthsv_pkg;

   // Each divider makes this many quotient bits, one per cell.
   localparam int QUO_BITS = 13;
   localparam int REM_BITS = 8;
   localparam int NUM_BITS = QUO_BITS + REM_BITS - 1;

   localparam logic [14:0] HUE_SIXTH = 15'd3840;
   localparam logic [14:0] HUE_FULL  = 15'd23040;
   localparam logic [14:0] HUE_GREEN = 15'd7680;
   localparam logic [14:0] HUE_BLUE  = 15'd15360;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] work;
      logic [REM_BITS-1:0] divisor;
   } div_lane_type;

   typedef struct packed {
      div_lane_type hue_lane;
      div_lane_type sat_lane;
      sector_type   sector;
      logic         diff_neg;
      logic [23:0]  packed_color;
   } cell_data_type;

   typedef struct packed {
      logic [23:0] packed_color;
      logic [7:0]  brightness;
      logic [12:0] saturation;
      logic [14:0] hue;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/rgb_to_hsv_pixel_core.sv @@
`default_nettype none
// RGB to HSV pixel converter. Each item is one 8-bit RGB pixel; each result gives hue in
// 1/64-degree units (0 to 23039), saturation as a fraction where 4096 is 1.0, value as the
// largest channel byte, and the pixel packed as red, green, blue into 24 bits. The block
// accepts one pixel every clock when nothing stalls. A pixel passes through a front register
// that finds the maximum, minimum and sector, thirteen cells of a divider row that each
// produce one quotient bit of hue and of saturation, and a fix-up stage into the output
// register. Stalls on the result side hold the row back only where it is full.
module rgb_to_hsv_pixel_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // red [7:0], green [15:8], blue [23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hue [14:0], saturation [27:15], brightness [35:28], packed_color [59:36], zero [63:60]
   output logic [63:0]      rsp_tdata
);

   localparam int NumCells = rthsv_pkg::QUO_BITS;

   logic                     stage_valid [NumCells+1];
   logic                     stage_ready [NumCells+1];
   rthsv_pkg::cell_data_type stage_data  [NumCells+1];
   rthsv_pkg::result_type    result;

   rthsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      rthsv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   rthsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NumCells]),
      .in_ready  (stage_ready[NumCells]),
      .in_data   (stage_data[NumCells]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {4'd0, result};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.hue < rthsv_pkg::HUE_FULL))
      else $error("hue out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.saturation <= 13'd4096))
      else $error("saturation above one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.brightness >= result.packed_color[23:16] &&
                      result.brightness >= result.packed_color[15:8] &&
                      result.brightness >= result.packed_color[7:0] &&
                      (result.brightness == result.packed_color[23:16] ||
                       result.brightness == result.packed_color[15:8] ||
                       result.brightness == result.packed_color[7:0])))
      else $error("brightness is not the largest channel");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.saturation == '0) |-> (result.hue == '0))
      else $error("gray pixel with nonzero hue");

endmodule
`default_nettype wire

@@ rtl/rthsv_front.sv @@
`default_nettype none
module rthsv_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [7:0]               red,
   input  wire logic [7:0]               green,
   input  wire logic [7:0]               blue,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rthsv_pkg::cell_data_type      out_data
);

   logic                     valid_ff;
   rthsv_pkg::cell_data_type data_ff;
   rthsv_pkg::cell_data_type data_in;

   logic [7:0]                      mx;
   logic [7:0]                      mn;
   logic [7:0]                      delta;
   logic [7:0]                      op_a;
   logic [7:0]                      op_b;
   logic [7:0]                      mag;
   rthsv_pkg::sector_type           sector;
   logic [rthsv_pkg::NUM_BITS-1:0]  hue_num;
   logic [rthsv_pkg::NUM_BITS-1:0]  sat_num;

   always_comb begin
      // Ties go to red first, then green.
      if (red >= green && red >= blue) begin
         sector = rthsv_pkg::SECTOR_RED;
         mx     = red;
         op_a   = green;
         op_b   = blue;
      end else if (green >= blue) begin
         sector = rthsv_pkg::SECTOR_GREEN;
         mx     = green;
         op_a   = blue;
         op_b   = red;
      end else begin
         sector = rthsv_pkg::SECTOR_BLUE;
         mx     = blue;
         op_a   = red;
         op_b   = green;
      end
      mn = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      delta = mx - mn;
      mag   = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
      // 3840 * |diff| as 4096 * |diff| - 256 * |diff|.
      hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};
      sat_num = {delta, 12'd0};

      data_in.hue_lane.rem     = {1'b0, hue_num[rthsv_pkg::NUM_BITS-1:rthsv_pkg::QUO_BITS]};
      data_in.hue_lane.work    = hue_num[rthsv_pkg::QUO_BITS-1:0];
      data_in.hue_lane.divisor = delta;
      data_in.sat_lane.rem     = {1'b0, sat_num[rthsv_pkg::NUM_BITS-1:rthsv_pkg::QUO_BITS]};
      data_in.sat_lane.work    = sat_num[rthsv_pkg::QUO_BITS-1:0];
      data_in.sat_lane.divisor = mx;
      data_in.sector           = sector;
      data_in.diff_neg         = (op_a < op_b);
      data_in.packed_color     = {red, green, blue};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/rthsv_cell.sv @@
`default_nettype none
module rthsv_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire rthsv_pkg::cell_data_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rthsv_pkg::cell_data_type      out_data
);

   logic                     valid_ff;
   rthsv_pkg::cell_data_type data_ff;
   rthsv_pkg::cell_data_type data_in;

   // One restoring division step: bring in the next numerator bit, try the subtract.
   function automatic rthsv_pkg::div_lane_type div_step(input rthsv_pkg::div_lane_type lane);
      rthsv_pkg::div_lane_type res;
      logic [rthsv_pkg::REM_BITS:0] trial;
      logic                         fits;
      trial = {lane.rem, lane.work[rthsv_pkg::QUO_BITS-1]};
      fits  = trial >= {1'b0, lane.divisor};
      res.divisor = lane.divisor;
      res.work    = {lane.work[rthsv_pkg::QUO_BITS-2:0], fits};
      if (fits) begin
         res.rem = rthsv_pkg::REM_BITS'(trial - {1'b0, lane.divisor});
      end else begin
         res.rem = trial[rthsv_pkg::REM_BITS-1:0];
      end
      return res;
   endfunction

   always_comb begin
      data_in          = in_data;
      data_in.hue_lane = div_step(in_data.hue_lane);
      data_in.sat_lane = div_step(in_data.sat_lane);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/rthsv_back.sv @@
`default_nettype none
module rthsv_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire rthsv_pkg::cell_data_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rthsv_pkg::result_type         out_data
);

   logic                  valid_ff;
   rthsv_pkg::result_type data_ff;
   rthsv_pkg::result_type data_in;

   logic [14:0] quo;
   logic [14:0] offset;
   logic        rem_nz;

   always_comb begin
      quo    = {3'd0, in_data.hue_lane.work[rthsv_pkg::QUO_BITS-2:0]};
      rem_nz = (in_data.hue_lane.rem != '0);
      case (in_data.sector)
         rthsv_pkg::SECTOR_GREEN: offset = rthsv_pkg::HUE_GREEN;
         rthsv_pkg::SECTOR_BLUE:  offset = rthsv_pkg::HUE_BLUE;
         default:                 offset = '0;
      endcase

      // The division ran on magnitudes. A negative difference truncates toward
      // zero in the red sector and wraps around the circle, but floors in the
      // other two, where the whole quotient stays positive.
      if (in_data.hue_lane.divisor == '0) begin
         data_in.hue = '0;
      end else if (!in_data.diff_neg) begin
         data_in.hue = offset + quo;
      end else if (in_data.sector == rthsv_pkg::SECTOR_RED) begin
         data_in.hue = (quo == '0) ? '0 : (rthsv_pkg::HUE_FULL - quo);
      end else begin
         data_in.hue = offset - quo - {14'd0, rem_nz};
      end

      if (in_data.sat_lane.divisor == '0) begin
         data_in.saturation = '0;
      end else begin
         data_in.saturation = in_data.sat_lane.work;
      end
      data_in.brightness   = in_data.sat_lane.divisor;
      data_in.packed_color = in_data.packed_color;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

@@ sim/rgb_to_hsv_pixel_core_tb.sv @@
`default_nettype none
module rgb_to_hsv_pixel_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIXTH_TURN    = 3840;
   localparam int FULL_TURN     = 23040;
   localparam int SAT_UNITY     = 4096;
   localparam int RESET_CYCLES  = 11;
   localparam int PHASE_PIXELS  = 275;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_MAX  = 2000;

   // One directed pixel; want is only meaningful when typed is set.
   typedef struct packed {
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic                  typed;
      rthsv_pkg::result_type want;
   } pixel_row_type;

   localparam int DIRECTED_ROWS = 23;

   pixel_row_type directed_pixels [DIRECTED_ROWS] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1,
        '{packed_color: 24'h000000, brightness: 8'd0,   saturation: 13'd0,    hue: 15'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1,
        '{packed_color: 24'hffffff, brightness: 8'd255, saturation: 13'd0,    hue: 15'd0}},
      '{8'd128, 8'd128, 8'd128, 1'b1,
        '{packed_color: 24'h808080, brightness: 8'd128, saturation: 13'd0,    hue: 15'd0}},
      '{8'd255, 8'd0,   8'd0,   1'b1,
        '{packed_color: 24'hff0000, brightness: 8'd255, saturation: 13'd4096, hue: 15'd0}},
      '{8'd0,   8'd255, 8'd0,   1'b1,
        '{packed_color: 24'h00ff00, brightness: 8'd255, saturation: 13'd4096, hue: 15'd7680}},
      '{8'd0,   8'd0,   8'd255, 1'b1,
        '{packed_color: 24'h0000ff, brightness: 8'd255, saturation: 13'd4096, hue: 15'd15360}},
      '{8'd1,   8'd0,   8'd0,   1'b1,
        '{packed_color: 24'h010000, brightness: 8'd1,   saturation: 13'd4096, hue: 15'd0}},
      // Ties for the maximum: red beats green and blue, green beats blue.
      '{8'd255, 8'd255, 8'd0,   1'b1,
        '{packed_color: 24'hffff00, brightness: 8'd255, saturation: 13'd4096, hue: 15'd3840}},
      '{8'd0,   8'd255, 8'd255, 1'b1,
        '{packed_color: 24'h00ffff, brightness: 8'd255, saturation: 13'd4096, hue: 15'd11520}},
      '{8'd255, 8'd0,   8'd255, 1'b1,
        '{packed_color: 24'hff00ff, brightness: 8'd255, saturation: 13'd4096, hue: 15'd19200}},
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},
      '{8'd1,   8'd1,   8'd0,   1'b0, '0},
      '{8'd0,   8'd1,   8'd1,   1'b0, '0},
      '{8'd1,   8'd0,   8'd1,   1'b0, '0},
      '{8'd254, 8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd254, 8'd254, 1'b0, '0},
      '{8'd200, 8'd100, 8'd50,  1'b0, '0},
      '{8'd50,  8'd200, 8'd100, 1'b0, '0},
      '{8'd100, 8'd50,  8'd200, 1'b0, '0},
      '{8'd1,   8'd2,   8'd3,   1'b0, '0},
      '{8'd255, 8'd128, 8'd127, 1'b0, '0},
      '{8'd0,   8'd0,   8'd1,   1'b0, '0},
      '{8'd170, 8'd85,  8'd255, 1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // hue [14:0], saturation [27:15], brightness [35:28], packed_color [59:36], zero [63:60]
   logic [63:0] rsp_tdata;

   rthsv_pkg::result_type hsv_expected [$];
   rthsv_pkg::result_type got_hsv;
   rthsv_pkg::result_type want_hsv;

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   bit hold_request    = 1'b0;
   int failures        = 0;
   int results_checked = 0;
   int quiet_cycles    = 0;
   int directed_count  = 0;
   int random_count    = 0;

   rgb_to_hsv_pixel_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic rthsv_pkg::result_type hsv_of(input logic [7:0] red,
                                                    input logic [7:0] green,
                                                    input logic [7:0] blue);
      int rv, gv, bv, peak, floor_v, span, offset, slope, angle, sat;
      rthsv_pkg::result_type res;
      rv = int'(red);
      gv = int'(green);
      bv = int'(blue);
      peak = (rv > gv) ? rv : gv;
      if (bv > peak) peak = bv;
      floor_v = (rv < gv) ? rv : gv;
      if (bv < floor_v) floor_v = bv;
      span = peak - floor_v;
      if (span == 0) begin
         angle = 0;
      end else begin
         if (rv == peak) begin
            offset = 0;
            slope  = gv - bv;
         end else if (gv == peak) begin
            offset = 2 * SIXTH_TURN;
            slope  = bv - rv;
         end else begin
            offset = 4 * SIXTH_TURN;
            slope  = rv - gv;
         end
         // Integer division truncates toward zero; negative angles wrap once.
         angle = (offset * span + SIXTH_TURN * slope) / span;
         if (angle < 0) angle += FULL_TURN;
      end
      sat = (peak == 0) ? 0 : (span * SAT_UNITY) / peak;
      res.hue          = angle[14:0];
      res.saturation   = sat[12:0];
      res.brightness   = peak[7:0];
      res.packed_color = {red, green, blue};
      return res;
   endfunction

   // Offers one pixel, holding it until the block takes it, then records its expected result.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input rthsv_pkg::result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      hsv_expected.push_back(want);
   endtask

   function automatic logic [7:0] rail_byte();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   task automatic pick_pixel(output logic [7:0] red, output logic [7:0] green,
                             output logic [7:0] blue);
      logic [7:0] top, low;
      top = 8'($urandom_range(255));
      low = 8'($urandom_range(top));
      case ($urandom_range(9))
         0: begin
            red   = top;
            green = top;
            blue  = top;
         end
         1: begin
            // Two channels share the maximum.
            case ($urandom_range(2))
               0: {red, green, blue} = {top, top, low};
               1: {red, green, blue} = {low, top, top};
               default: {red, green, blue} = {top, low, top};
            endcase
         end
         2: begin
            red   = rail_byte();
            green = rail_byte();
            blue  = rail_byte();
         end
         default: begin
            red   = 8'($urandom_range(255));
            green = 8'($urandom_range(255));
            blue  = 8'($urandom_range(255));
         end
      endcase
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      logic [7:0] red, green, blue;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_PIXELS) begin
         pick_pixel(red, green, blue);
         send_pixel(red, green, blue, hsv_of(red, green, blue));
         random_count++;
      end
   endtask

   // Result side ready, with random stalls at recv_stall_pct and a long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         got_hsv = rthsv_pkg::result_type'(rsp_tdata[59:0]);
         if (hsv_expected.size() == 0) begin
            $error("unexpected result item: %h", rsp_tdata);
            failures++;
         end else begin
            want_hsv = hsv_expected.pop_front();
            if (got_hsv.hue !== want_hsv.hue) begin
               $error("hue: expected %0d, got %0d", want_hsv.hue, got_hsv.hue);
               failures++;
            end
            if (got_hsv.saturation !== want_hsv.saturation) begin
               $error("saturation: expected %0d, got %0d",
                      want_hsv.saturation, got_hsv.saturation);
               failures++;
            end
            if (got_hsv.brightness !== want_hsv.brightness) begin
               $error("brightness: expected %0d, got %0d",
                      want_hsv.brightness, got_hsv.brightness);
               failures++;
            end
            if (got_hsv.packed_color !== want_hsv.packed_color) begin
               $error("packed_color: expected %h, got %h",
                      want_hsv.packed_color, got_hsv.packed_color);
               failures++;
            end
         end
      end
   end

   // Ends the run if no item moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
         $display("no item moved for %0d cycles", WATCHDOG_MAX);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_pixel(directed_pixels[i].red, directed_pixels[i].green, directed_pixels[i].blue,
                    directed_pixels[i].typed ? directed_pixels[i].want
                       : hsv_of(directed_pixels[i].red, directed_pixels[i].green,
                                directed_pixels[i].blue));
         directed_count++;
      end

      // The sender keeps streaming while the result side stalls, so the pipeline backs up.
      hold_request = 1'b1;
      run_random_phase(0, 0);
      run_random_phase(46, 0);
      run_random_phase(0, 46);
      run_random_phase(32, 32);
      req_tvalid <= 1'b0;

      while (hsv_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels (%0d directed, %0d random) under four throttling mixes",
               directed_count + random_count, directed_count, random_count);
      $display("and one %0d-cycle result stall; %0d results checked.",
               HOLD_CYCLES, results_checked);
      if (failures == 0 && hsv_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
